FILE: rtl/bfa_pkg.sv
// shared types, codes and the lowest-free-bit search for the bitmap allocator
package bfa_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W = 5;
    localparam int FREE_W = 11;
    localparam int INDEX_W = 10;
    localparam logic [FREE_W-1:0] FREE_MAX = 11'h7FF;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_SET = 2'd2;

    localparam logic [1:0] STAT_ALLOC = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
    } find_t;

    // lowest set bit of a word of candidate free bits
    function automatic find_t find_low(input logic [WORD_W-1:0] cand);
        find_t res;
        res.hit = 1'b0;
        res.pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                res.hit = 1'b1;
                res.pos = BIT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/bfa_ram.sv
// generic single-write, single-read ram with registered read data
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bitmap_first_free_allocator.sv
// bitmap allocator top level: command sequencer, word scan and apb register
// One command per start transfer while busy is low; each command gives one result on
// done for a single cycle, and the receiver cannot stall it. Load, set-count and an
// allocate with a zero search length finish without a scan; done is registered and
// rises in the cycle after the command is taken. An allocate reads one bitmap word
// per cycle from the single read port of the bitmap ram and checks it with one 32-bit
// free-bit search: it stays busy until it claims a bit (write-back of the claimed word
// happens in its last scan cycle) or until the searched bytes are all taken. After
// reset a clearing pass writes every bitmap word to zero, one word a cycle, with busy
// high; register writes are taken throughout.
module bitmap_first_free_allocator #(
    parameter int MAP_WORDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [4:0]  word_index,
    input  logic [31:0] word_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  alloc_index,
    output logic [10:0] free_left,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bfa_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [12:0] LEN_MAX = 13'(4 * MAP_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [10:0] WORDS_LIM = 11'(MAP_WORDS);

    state_t               state_reg, state_next;
    logic [AW-1:0]        word_reg, word_next;
    logic [7:0]           bytes_left_reg, bytes_left_next;
    logic [FREE_W-1:0]    free_count_reg, free_count_next;
    logic [7:0]           search_len_reg;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [INDEX_W-1:0]   index_reg, index_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 cfg_write;
    logic [7:0]           len_clamp;
    logic [AW+4:0]        widx_wide;
    logic                 widx_ok;
    logic [WORD_W-1:0]    span_mask;
    find_t                find;
    logic [AW+4:0]        pos_full;
    logic [AW+14:0]       pos_pad;
    logic [FREE_W-1:0]    set_value;

    bfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // apb register
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, search_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_len_reg <= 8'd128;
        end
        else if (cfg_write && (paddr[2] == 1'b0))
        begin
            search_len_reg <= pwdata[7:0];
        end
    end

    assign accept = start && !busy;
    assign len_clamp = ({5'd0, search_len_reg} > LEN_MAX) ? LEN_MAX[7:0] : search_len_reg;
    assign widx_wide = {AW'(0), word_index};
    assign widx_ok = ({6'd0, word_index} < WORDS_LIM);
    assign set_value = (word_data > 32'(FREE_MAX)) ? FREE_MAX : word_data[FREE_W-1:0];

    always_comb
    begin
        case (bytes_left_reg)
            8'd1: span_mask = 32'h0000_00FF;
            8'd2: span_mask = 32'h0000_FFFF;
            8'd3: span_mask = 32'h00FF_FFFF;
            default: span_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign find = find_low(~ram_rdata & span_mask);
    assign pos_full = {word_reg, find.pos};
    assign pos_pad = {10'd0, pos_full};

    always_comb
    begin
        state_next = state_reg;
        word_next = word_reg;
        bytes_left_next = bytes_left_reg;
        free_count_next = free_count_reg;
        done_next = 1'b0;
        status_next = status_reg;
        index_next = index_reg;
        ram_we = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = ram_rdata | (WORD_W'(1) << find.pos);
        ram_raddr = AW'(word_reg + AW'(1));
        busy = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_wdata = '0;
                word_next = AW'(word_reg + AW'(1));
                if (word_reg == LAST_WORD)
                begin
                    word_next = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                busy = 1'b0;
                ram_raddr = '0;
                if (accept)
                begin
                    index_next = '0;
                    status_next = STAT_DONE;
                    done_next = 1'b1;
                    case (command)
                        CMD_ALLOC:
                        begin
                            if (len_clamp == 8'd0)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                word_next = '0;
                                bytes_left_next = len_clamp;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LOAD:
                        begin
                            ram_we = widx_ok;
                            ram_waddr = widx_wide[AW-1:0];
                            ram_wdata = word_data;
                        end
                        CMD_SET:
                        begin
                            free_count_next = set_value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (find.hit)
                begin
                    ram_we = 1'b1;
                    if (free_count_reg != '0)
                    begin
                        free_count_next = free_count_reg - FREE_W'(1);
                    end
                    status_next = STAT_ALLOC;
                    index_next = pos_pad[INDEX_W-1:0];
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (bytes_left_reg <= 8'd4)
                begin
                    status_next = STAT_FULL;
                    index_next = '0;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = AW'(word_reg + AW'(1));
                    bytes_left_next = bytes_left_reg - 8'd4;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            word_reg <= '0;
            bytes_left_reg <= '0;
            free_count_reg <= '0;
            done_reg <= 1'b0;
            status_reg <= STAT_DONE;
            index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg <= word_next;
            bytes_left_reg <= bytes_left_next;
            free_count_reg <= free_count_next;
            done_reg <= done_next;
            status_reg <= status_next;
            index_reg <= index_next;
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign alloc_index = index_reg;
    assign free_left = free_count_reg;

    // a result is only ever shown while a new transfer can be taken
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_ALLOC)) |-> (alloc_index == 10'd0))
        else $error("index not zero without allocation");

    a_free_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_ALLOC) && ($past(free_left) != 11'd0))
        |-> (free_left == ($past(free_left) - 11'd1)))
        else $error("free counter not decremented on allocation");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (16'(word_reg) < 16'(MAP_WORDS)))
        else $error("scan beyond bitmap");

endmodule
